>>> src/pcm_slot_pitch_allocator_assert.svh
// Assertion macros shared by the allocator modules.
`ifndef PCM_SLOT_PITCH_ALLOCATOR_ASSERT_SVH
`define PCM_SLOT_PITCH_ALLOCATOR_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define PSA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the following cycle.
`define PSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/psa_pkg.sv
package psa_pkg;

  // Default number of sample slots.
  localparam int SLOT_LIMIT_DEF = 128;

  // Sound memory layout.
  localparam logic [19:0] LOAD_RESET = 20'h02C28;
  localparam logic [19:0] LOAD_LIMIT = 20'h7F800;

  // Pitch reference frequency.
  localparam int BASE_FREQ = 44100;

  // Frames per second for each region.
  localparam logic [15:0] FPS_PAL  = 16'd50;
  localparam logic [15:0] FPS_NTSC = 16'd60;

  // Rounded-up reciprocals of the frame rates, scaled by 2^RECIP_SHIFT.
  // The rounding error stays small enough that the shifted product equals
  // the truncated quotient for every 17-bit numerator.
  localparam int RECIP_SHIFT = 23;
  localparam int RECIP_W     = 18;
  localparam logic [RECIP_W-1:0] RECIP_PAL =
    RECIP_W'(((1 << RECIP_SHIFT) + int'(FPS_PAL) - 1) / int'(FPS_PAL));
  localparam logic [RECIP_W-1:0] RECIP_NTSC =
    RECIP_W'(((1 << RECIP_SHIFT) + int'(FPS_NTSC) - 1) / int'(FPS_NTSC));

  // Serial divider geometry: dividend bits, divisor bits, step counter bits.
  localparam int DIV_W  = 26;
  localparam int DVSR_W = 16;
  localparam int DCNT_W = $clog2(DIV_W);

  // Configuration port geometry and register indexes.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_PAL_REGION = 1'b0;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE     = 4'b0001,
    ST_SETUP    = 4'b0010,
    ST_FNS_RUN  = 4'b0100,
    ST_PUBLISH  = 4'b1000
  } psa_state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;
    logic fns_start;
    logic fns_save;
    logic publish;
  } psa_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic ok;
    logic div_done;
    logic out_free;
  } psa_stat_t;

  // Octave reference: base frequency shifted down by the octave.
  function automatic logic [15:0] shift_of(input logic [3:0] oct);
    logic [15:0] base;
    base = 16'(BASE_FREQ);
    return base >> oct;
  endfunction

endpackage

>>> src/psa_div.sv
`include "pcm_slot_pitch_allocator_assert.svh"

module psa_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [psa_pkg::DIV_W-1:0]   dividend,
  input  logic [psa_pkg::DVSR_W-1:0]  divisor,
  output logic                        busy,
  output logic                        done,
  output logic [psa_pkg::DIV_W-1:0]   quotient
);
  import psa_pkg::*;

  logic [DIV_W-1:0]  q_r, q_nxt;
  logic [DVSR_W-1:0] rem_r, rem_nxt;
  logic [DVSR_W-1:0] dvsr_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DVSR_W:0]   trial;
  logic              ge;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    trial   = {rem_r, q_r[DIV_W-1]};
    ge      = trial >= {1'b0, dvsr_r};
    rem_nxt = ge ? DVSR_W'(trial - {1'b0, dvsr_r}) : trial[DVSR_W-1:0];
    q_nxt   = {q_r[DIV_W-2:0], ge};
  end

  // Step control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == DCNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (start) begin
      q_r    <= dividend;
      rem_r  <= '0;
      dvsr_r <= divisor;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = q_r;

  `PSA_ASSERT_SAME(a_div_rem_below, clk, rst_n, busy_r && !start, rem_r < dvsr_r, "remainder not below divisor")
  `PSA_ASSERT_NEXT(a_div_done_ends, clk, rst_n, done_r, !done_r || start, "done held for two cycles")
  `PSA_ASSERT_SAME(a_div_no_overlap, clk, rst_n, done_r, !busy_r, "done while still busy")

endmodule

>>> src/psa_dpath.sv
`include "pcm_slot_pitch_allocator_assert.svh"

module psa_dpath #(
  parameter int SLOT_LIMIT = psa_pkg::SLOT_LIMIT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  psa_pkg::psa_cmd_t             cmd,
  output psa_pkg::psa_stat_t            st,
  input  logic [15:0]                   in_sample_rate,
  input  logic [18:0]                   in_byte_size,
  input  logic                          in_is_8bit,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [psa_pkg::PADDR_W-1:0]   paddr,
  input  logic [psa_pkg::PDATA_W-1:0]   pwdata,
  output logic [psa_pkg::PDATA_W-1:0]   prdata,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_accepted,
  output logic [6:0]                    out_slot_number,
  output logic [18:0]                   out_start_address,
  output logic [14:0]                   out_pitch_word,
  output logic [19:0]                   out_play_size,
  output logic [11:0]                   out_bytes_per_frame
);
  import psa_pkg::*;

  localparam int CNT_BITS = $clog2(SLOT_LIMIT + 1);
  localparam int CNT_W    = (CNT_BITS > 7) ? CNT_BITS : 7;
  localparam int PROD_W   = 17 + RECIP_W;

  // Allocator state and configuration.
  logic             pal_r;
  logic [19:0]      ptr_r, ptr_nxt;
  logic [CNT_W-1:0] slots_r, slots_nxt;

  // Captured request.
  logic        ok_r;
  logic [15:0] rate_r;
  logic [3:0]  oct_r;
  logic        neg_r;
  logic [6:0]  slot_r;
  logic [18:0] start_r;
  logic [19:0] psize_r;
  logic [9:0]  fns_r;
  logic [11:0] bpf_r;

  // Output register.
  logic        out_valid_r;
  logic        out_acc_r;
  logic [6:0]  out_slot_r;
  logic [18:0] out_start_r;
  logic [14:0] out_pitch_r;
  logic [19:0] out_psize_r;
  logic [11:0] out_bpf_r;

  // Request decode.
  logic        ok_in;
  logic [19:0] aligned;
  logic [19:0] psize_in;
  logic [16:0] rate1;
  logic [3:0]  oct_in;

  // Bytes per frame.
  logic [16:0]        bpf_num_in;
  logic [RECIP_W-1:0] recip_val;
  logic [PROD_W-1:0]  bpf_prod;
  logic [11:0]        bpf_in;

  // Divider interface.
  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  logic [DVSR_W-1:0] div_divisor;
  logic             div_busy;
  logic             div_done;
  logic [DIV_W-1:0] div_q;
  logic [15:0]      shift_val;
  logic [15:0]      diff_mag;
  logic [DIV_W-1:0] q_neg;

  // Admission check, alignment and play size.
  always_comb begin
    ok_in    = !(ptr_r > LOAD_LIMIT) && !(slots_r >= CNT_W'(SLOT_LIMIT));
    aligned  = (20'(in_byte_size) + 20'd3) & ~20'd3;
    psize_in = in_is_8bit ? aligned : (aligned >> 1);
    rate1    = 17'(in_sample_rate) + 17'd1;
  end

  // Octave: count the powers of two that fit the base frequency ratio.
  always_comb begin
    oct_in = '0;
    for (int k = 0; k < 8; k++) begin
      if ((25'(rate1) << k) <= 25'(BASE_FREQ)) begin
        oct_in = oct_in + 4'd1;
      end
    end
  end

  // Bytes per frame: multiply by the scaled reciprocal of the frame rate.
  always_comb begin
    bpf_num_in = in_is_8bit ? 17'(in_sample_rate) : {in_sample_rate, 1'b0};
    recip_val  = pal_r ? RECIP_PAL : RECIP_NTSC;
    bpf_prod   = PROD_W'(bpf_num_in) * PROD_W'(recip_val);
    bpf_in     = bpf_prod[RECIP_SHIFT +: 12];
  end

  // Advance pointer and slot count on an admitted request.
  always_comb begin
    ptr_nxt   = ptr_r;
    slots_nxt = slots_r;
    if (cmd.load && ok_in) begin
      ptr_nxt   = ptr_r + aligned;
      slots_nxt = slots_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_r   <= 1'b0;
      ptr_r   <= LOAD_RESET;
      slots_r <= '0;
    end else begin
      if (psel && penable && pwrite && (paddr[2] == REG_PAL_REGION)) begin
        pal_r <= pwdata[0];
      end
      ptr_r   <= ptr_nxt;
      slots_r <= slots_nxt;
    end
  end

  // Register read.
  assign prdata = (paddr[2] == REG_PAL_REGION) ? PDATA_W'(pal_r) : '0;

  // Capture the request.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ok_r    <= ok_in;
      rate_r  <= in_sample_rate;
      oct_r   <= oct_in;
      slot_r  <= slots_r[6:0];
      start_r <= ptr_r[18:0];
      psize_r <= psize_in;
      bpf_r   <= bpf_in;
    end
  end

  // Divider operands for the pitch fraction.
  always_comb begin
    shift_val    = shift_of(oct_r);
    diff_mag     = (rate_r >= shift_val) ? (rate_r - shift_val) : (shift_val - rate_r);
    div_start    = cmd.fns_start;
    div_dividend = {diff_mag, 10'd0};
    div_divisor  = shift_val;
    q_neg        = '0 - div_q;
  end

  psa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // Hold sign of the pitch fraction; keep the quotient.
  always_ff @(posedge clk) begin
    if (cmd.fns_start) begin
      neg_r <= rate_r < shift_val;
    end
    if (cmd.fns_save) begin
      fns_r <= neg_r ? q_neg[9:0] : div_q[9:0];
    end
  end

  // Output beat register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_acc_r   <= ok_r;
      out_slot_r  <= ok_r ? slot_r : '0;
      out_start_r <= ok_r ? start_r : '0;
      out_pitch_r <= ok_r ? {4'(4'd0 - oct_r), 1'b0, fns_r} : '0;
      out_psize_r <= ok_r ? psize_r : '0;
      out_bpf_r   <= ok_r ? bpf_r : '0;
    end
  end

  assign st.ok       = ok_r;
  assign st.div_done = div_done;
  assign st.out_free = !out_valid_r || out_ready;

  assign out_valid           = out_valid_r;
  assign out_accepted        = out_acc_r;
  assign out_slot_number     = out_slot_r;
  assign out_start_address   = out_start_r;
  assign out_pitch_word      = out_pitch_r;
  assign out_play_size       = out_psize_r;
  assign out_bytes_per_frame = out_bpf_r;

  `PSA_ASSERT_SAME(a_dp_start_idle, clk, rst_n, div_start, !div_busy, "divider started while busy")
  `PSA_ASSERT_SAME(a_dp_publish_free, clk, rst_n, cmd.publish,
                   !out_valid_r || out_ready, "result beat overwritten")
  `PSA_ASSERT_NEXT(a_dp_slot_step, clk, rst_n, cmd.load && ok_in,
                   slots_r == $past(slots_r) + 1'b1, "slot count did not advance")
  `PSA_ASSERT_SAME(a_dp_ptr_bound, clk, rst_n, 1'b1, ptr_r <= 20'hFF800, "load pointer out of range")

endmodule

>>> src/psa_ctrl.sv
module psa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  psa_pkg::psa_stat_t  st,
  output psa_pkg::psa_cmd_t   cmd
);
  import psa_pkg::*;

  psa_state_t state_r, state_nxt;

  // Sequence one request: capture, pitch division for an admitted request, publish.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (st.ok) begin
          cmd.fns_start = 1'b1;
          state_nxt     = ST_FNS_RUN;
        end else begin
          state_nxt = ST_PUBLISH;
        end
      end
      ST_FNS_RUN: begin
        if (st.div_done) begin
          cmd.fns_save = 1'b1;
          state_nxt    = ST_PUBLISH;
        end
      end
      ST_PUBLISH: begin
        if (st.out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> src/pcm_slot_pitch_allocator.sv
// PCM slot and pitch allocator. Each input beat registers one sample: the block
// checks the sound memory pointer and slot count, then returns the slot, the start
// address, the aligned play size, the octave/FNS pitch word and the bytes consumed
// per video frame (50 or 60 frames per second from the pal_region register at
// byte address 0). One request is handled at a time. Between input beat and
// result beat, an admitted request runs the 26-step serial divider that forms
// the pitch fraction; bytes per frame come from a reciprocal multiply at
// capture. A rejected one skips the divider. A finished result waits in the
// output register, and the next input beat is taken while it waits.
module pcm_slot_pitch_allocator #(
  parameter int SLOT_LIMIT = psa_pkg::SLOT_LIMIT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [15:0]                   in_sample_rate,
  input  logic [18:0]                   in_byte_size,
  input  logic                          in_is_8bit,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_accepted,
  output logic [6:0]                    out_slot_number,
  output logic [18:0]                   out_start_address,
  output logic [14:0]                   out_pitch_word,
  output logic [19:0]                   out_play_size,
  output logic [11:0]                   out_bytes_per_frame,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [psa_pkg::PADDR_W-1:0]   paddr,
  input  logic [psa_pkg::PDATA_W-1:0]   pwdata,
  output logic [psa_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import psa_pkg::*;

  psa_cmd_t  cmd;
  psa_stat_t st;

  // Configuration port never stalls.
  assign pready = 1'b1;

  psa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  psa_dpath #(
    .SLOT_LIMIT (SLOT_LIMIT)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .st                  (st),
    .in_sample_rate      (in_sample_rate),
    .in_byte_size        (in_byte_size),
    .in_is_8bit          (in_is_8bit),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_accepted        (out_accepted),
    .out_slot_number     (out_slot_number),
    .out_start_address   (out_start_address),
    .out_pitch_word      (out_pitch_word),
    .out_play_size       (out_play_size),
    .out_bytes_per_frame (out_bytes_per_frame)
  );

endmodule

>>> tb/alloc_checker.sv
`timescale 1ns / 1ps

module alloc_checker #(
  parameter int SLOT_LIMIT = psa_pkg::SLOT_LIMIT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [15:0]                 in_sample_rate,
  input  logic [18:0]                 in_byte_size,
  input  logic                        in_is_8bit,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic                        out_accepted,
  input  logic [6:0]                  out_slot_number,
  input  logic [18:0]                 out_start_address,
  input  logic [14:0]                 out_pitch_word,
  input  logic [19:0]                 out_play_size,
  input  logic [11:0]                 out_bytes_per_frame,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [psa_pkg::PADDR_W-1:0] paddr,
  input  logic [psa_pkg::PDATA_W-1:0] pwdata,
  output int                          fails,
  output int                          pending
);

  localparam int PAL_ADDR_INT = 4 * psa_pkg::REG_PAL_REGION;
  localparam int PRINT_LIMIT  = 40;

  typedef struct packed {
    logic        accepted;
    logic [6:0]  slot;
    logic [18:0] start;
    logic [14:0] pitch;
    logic [19:0] play;
    logic [11:0] bpf;
  } alloc_grant_t;

  // Shadow of the allocator state and the region register
  logic         pal_sel;
  logic [19:0]  mem_ptr;
  int           slots_taken;
  alloc_grant_t grants_due[$];
  alloc_grant_t want;

  initial begin
    fails   = 0;
    pending = 0;
  end

  task automatic report_mismatch(input string what);
    if (fails < PRINT_LIMIT) $display("[%0t] allocator mismatch: %s", $time, what);
    fails++;
  endtask

  // Octave from the saturated divide index, then the signed FNS fraction
  function automatic logic [14:0] pitch_word_for(input logic [15:0] rate);
    int     idx;
    int     oct;
    longint step;
    longint frac;
    logic [3:0] neg_oct;
    idx = 44100 / (int'(rate) + 1);
    if (idx > 255) idx = 255;
    oct = 0;
    while (idx != 0) begin
      oct++;
      idx = idx >> 1;
    end
    step = longint'(psa_pkg::BASE_FREQ >> oct);
    frac = ((longint'(rate) - step) * 1024) / step;
    neg_oct = 4'(-oct);
    return {neg_oct, 1'b0, frac[9:0]};
  endfunction

  // Grant or reject one request; on a grant, advance the bump pointer and slot count
  function automatic alloc_grant_t predict_grant(input logic [15:0] rate,
                                                 input logic [18:0] size,
                                                 input logic is8);
    alloc_grant_t g;
    logic [19:0]  aligned;
    int           per_frame;
    int           fps;
    g = '0;
    if (mem_ptr > psa_pkg::LOAD_LIMIT || slots_taken >= SLOT_LIMIT) return g;
    aligned   = ({1'b0, size} + 20'd3) & ~20'd3;
    fps       = pal_sel ? int'(psa_pkg::FPS_PAL) : int'(psa_pkg::FPS_NTSC);
    per_frame = (is8 ? int'(rate) : 2 * int'(rate)) / fps;
    g.accepted = 1'b1;
    g.slot     = 7'(slots_taken);
    g.start    = mem_ptr[18:0];
    g.pitch    = pitch_word_for(rate);
    g.play     = is8 ? aligned : (aligned >> 1);
    g.bpf      = 12'(per_frame);
    slots_taken++;
    mem_ptr = mem_ptr + aligned;
    return g;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      pal_sel     = 1'b0;
      mem_ptr     = psa_pkg::LOAD_RESET;
      slots_taken = 0;
      grants_due.delete();
    end else begin
      // Track region writes
      if (psel && penable && pwrite && pready &&
          paddr == PAL_ADDR_INT[psa_pkg::PADDR_W-1:0])
        pal_sel = pwdata[0];

      // Predict on each request beat
      if (in_valid && in_ready)
        grants_due.push_back(predict_grant(in_sample_rate, in_byte_size, in_is_8bit));

      // Compare each result beat against the oldest prediction
      if (out_valid && out_ready) begin
        if (grants_due.size() == 0) begin
          report_mismatch("result beat with no request outstanding");
        end else begin
          want = grants_due.pop_front();
          if (out_accepted !== want.accepted)
            report_mismatch($sformatf("accepted got %0d want %0d",
                                      out_accepted, want.accepted));
          if (out_slot_number !== want.slot)
            report_mismatch($sformatf("slot_number got %0d want %0d",
                                      out_slot_number, want.slot));
          if (out_start_address !== want.start)
            report_mismatch($sformatf("start_address got 0x%0h want 0x%0h",
                                      out_start_address, want.start));
          if (out_pitch_word !== want.pitch)
            report_mismatch($sformatf("pitch_word got 0x%0h want 0x%0h",
                                      out_pitch_word, want.pitch));
          if (out_play_size !== want.play)
            report_mismatch($sformatf("play_size got %0d want %0d",
                                      out_play_size, want.play));
          if (out_bytes_per_frame !== want.bpf)
            report_mismatch($sformatf("bytes_per_frame got %0d want %0d",
                                      out_bytes_per_frame, want.bpf));
        end
      end
    end
    pending <= grants_due.size();
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int SLOTS        = psa_pkg::SLOT_LIMIT_DEF;
  localparam int TOTAL_ITEMS  = 1550;
  localparam int PHASE_LEN    = 27;
  localparam int NOISE_PHASE  = 500;
  localparam int HOLD_BEAT    = 30;
  localparam int HOLD_CYCLES  = 400;
  localparam int SIZE_CEILING = 'h60000;
  localparam int PAL_ADDR_INT = 4 * psa_pkg::REG_PAL_REGION;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic [15:0]                 in_sample_rate;
  logic [18:0]                 in_byte_size;
  logic                        in_is_8bit;
  logic                        out_valid;
  logic                        out_ready;
  logic                        out_accepted;
  logic [6:0]                  out_slot_number;
  logic [18:0]                 out_start_address;
  logic [14:0]                 out_pitch_word;
  logic [19:0]                 out_play_size;
  logic [11:0]                 out_bytes_per_frame;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [psa_pkg::PADDR_W-1:0] paddr;
  logic [psa_pkg::PDATA_W-1:0] pwdata;
  logic [psa_pkg::PDATA_W-1:0] prdata;
  logic                        pready;

  int fails;
  int pending;
  int sent;
  int mem_plan;
  int slots_plan;
  int send_calm;
  int recv_calm;
  int stall_left;
  int result_beats;
  bit hold_done;

  pcm_slot_pitch_allocator #(.SLOT_LIMIT(SLOTS)) DUT (.*);

  alloc_checker #(.SLOT_LIMIT(SLOTS)) grant_check (
    .clk, .rst_n, .in_valid, .in_ready, .in_sample_rate, .in_byte_size, .in_is_8bit,
    .out_valid, .out_ready, .out_accepted, .out_slot_number, .out_start_address,
    .out_pitch_word, .out_play_size, .out_bytes_per_frame,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fails, .pending
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Mostly short gaps, a few long ones, and calm stretches with none
  function automatic int pick_gap(inout int calm);
    int roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    roll = int'($urandom_range(0, 99));
    if (roll < 3) begin
      calm = int'($urandom_range(20, 60));
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 90) return int'($urandom_range(1, 3));
    if (roll < 98) return int'($urandom_range(4, 12));
    return int'($urandom_range(20, 60));
  endfunction

  // Offer one request beat, hold it until taken, then idle for a random gap
  task automatic send_sample(input logic [15:0] rate, input logic [18:0] size,
                             input logic is8);
    int gap;
    in_valid       <= 1'b1;
    in_sample_rate <= rate;
    in_byte_size   <= size;
    in_is_8bit     <= is8;
    do @(posedge clk); while (!in_ready);
    sent++;
    if (mem_plan <= int'(psa_pkg::LOAD_LIMIT) && slots_plan < SLOTS) begin
      mem_plan += (int'(size) + 3) & ~3;
      slots_plan++;
    end
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the region register while the block is idle
  task automatic set_region(input logic pal);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PAL_ADDR_INT[psa_pkg::PADDR_W-1:0];
    pwdata  <= {{(psa_pkg::PDATA_W-1){1'b0}}, pal};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Result side: random stalls after beats, plus one long hold-off
  initial begin
    out_ready <= 1'b0;
    stall_left   = 0;
    result_beats = 0;
    hold_done    = 1'b0;
    recv_calm    = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        result_beats++;
        stall_left = pick_gap(recv_calm);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      if (!hold_done && result_beats == HOLD_BEAT) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
        stall_left = 0;
      end else begin
        out_ready <= (stall_left == 0);
      end
    end
  end

  // Request side and verdict
  initial begin
    logic [15:0] rate;
    logic [18:0] size;
    int          roll;
    int          phase_items;
    logic        region;

    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_sample_rate <= '0;
    in_byte_size   <= '0;
    in_is_8bit     <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    sent       = 0;
    mem_plan   = int'(psa_pkg::LOAD_RESET);
    slots_plan = 0;
    send_calm  = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed at 60 fps: saturated low rates, octave edges, top rates, small sizes
    set_region(1'b0);
    send_sample(16'd0,     19'd0,    1'b1);
    send_sample(16'd1,     19'd1,    1'b0);
    send_sample(16'd171,   19'd2,    1'b1);
    send_sample(16'd172,   19'd3,    1'b0);
    send_sample(16'd44099, 19'd4,    1'b1);
    send_sample(16'd44100, 19'd5,    1'b0);
    send_sample(16'd44101, 19'd6,    1'b1);
    send_sample(16'd65535, 19'd7,    1'b0);
    send_sample(16'd22050, 19'd1000, 1'b1);
    send_sample(16'd8000,  19'd4095, 1'b0);

    // Directed at 50 fps: largest bytes per frame
    set_region(1'b1);
    send_sample(16'd65535, 19'd8,     1'b0);
    send_sample(16'd65535, 19'd9,     1'b1);
    send_sample(16'd0,     19'd0,     1'b0);
    send_sample(16'd11025, 19'h007FF, 1'b0);
    send_sample(16'd32000, 19'd2,     1'b1);

    // Random registrations, region flipped every phase, pointer kept under a ceiling
    region = 1'b0;
    set_region(region);
    phase_items = 0;
    while (slots_plan < SLOTS - 4) begin
      if (phase_items == PHASE_LEN) begin
        region = !region;
        set_region(region);
        phase_items = 0;
      end
      roll = int'($urandom_range(0, 9));
      if (roll < 5) rate = 16'($urandom_range(0, 65535));
      else if (roll < 7) rate = 16'($urandom_range(0, 511));
      else if (roll < 9) rate = 16'($urandom_range(43900, 44300));
      else rate = 16'($urandom_range(1, 16) * 4000);
      roll = int'($urandom_range(0, 9));
      if (roll < 7) size = 19'($urandom_range(0, 2047));
      else if (roll < 9) size = 19'($urandom_range(0, 16383));
      else size = 19'($urandom_range(0, 131071));
      if (mem_plan + int'(size) > SIZE_CEILING) size = 19'($urandom_range(0, 255));
      send_sample(rate, size, 1'($urandom_range(0, 1)));
      phase_items++;
    end

    // Land the pointer exactly on the load limit
    send_sample(16'($urandom_range(0, 65535)), 19'(int'(psa_pkg::LOAD_LIMIT) - mem_plan),
                1'($urandom_range(0, 1)));
    if ($urandom_range(0, 1) == 0) begin
      // Fill the last slots with empty samples, leaving the pointer at the limit
      while (slots_plan < SLOTS)
        send_sample(16'($urandom_range(0, 65535)), 19'd0, 1'($urandom_range(0, 1)));
    end else begin
      // Take one more sample at the limit, pushing the pointer past it
      send_sample(16'($urandom_range(0, 65535)), 19'($urandom_range(1, 'h7FFFF)),
                  1'($urandom_range(0, 1)));
    end

    // Every request from here on is rejected; sweep the full field ranges
    phase_items = 0;
    while (sent < TOTAL_ITEMS) begin
      if (phase_items == NOISE_PHASE) begin
        region = !region;
        set_region(region);
        phase_items = 0;
      end
      send_sample(16'($urandom_range(0, 65535)), 19'($urandom_range(0, 'h7FFFF)),
                  1'($urandom_range(0, 1)));
      phase_items++;
    end

    wait_idle();
    repeat (100) @(posedge clk);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #(10_000_000);
    $display("FAILURE");
    $finish;
  end

endmodule

>>> pcm_slot_pitch_allocator.f
+incdir+src
src/psa_pkg.sv
src/psa_div.sv
src/psa_dpath.sv
src/psa_ctrl.sv
src/pcm_slot_pitch_allocator.sv
tb/alloc_checker.sv
tb/tb.sv
